@@ hw/rtl/mmq_pkg.sv @@
// package: types and constants of the message match queue
`default_nettype none
package mmq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned TagW         = 32;
  localparam int unsigned SrcW         = 4;
  localparam int unsigned LenW         = 31;
  localparam int unsigned RefW         = 16;
  localparam int unsigned OccW         = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_TAKE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [TagW-1:0] tag;
    logic [SrcW-1:0]        source;
    logic [LenW-1:0]        length;
    logic [RefW-1:0]        pref;
  } entry_t;

  typedef struct packed {
    logic   found;
    entry_t entry;
  } chain_t;

  typedef struct packed {
    logic cmp;
    logic exe;
    op_e  op;
  } ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/mmq_cell.sv @@
// one queue slot: stores an entry, compares it, shifts down on removal
`default_nettype none
module mmq_cell #(
  parameter int unsigned DEPTH = mmq_pkg::DepthDefault,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mmq_pkg::ctl_t   ctl_i,
  input  wire mmq_pkg::entry_t req_i,
  input  wire logic [CW-1:0]   count_i,
  input  wire mmq_pkg::entry_t next_i,
  input  wire mmq_pkg::chain_t chain_i,
  output mmq_pkg::chain_t      chain_o,
  output mmq_pkg::entry_t      entry_o
);

  mmq_pkg::entry_t entry_q, entry_d;
  logic            hit_q, hit_d;
  logic            valid, last, eq, remove;

  assign valid = CW'(IDX) < count_i;
  assign last  = count_i == CW'(IDX + 1);
  assign eq    = (entry_q.tag == req_i.tag) && (entry_q.source == req_i.source)
              && (entry_q.length == req_i.length);

  always_comb begin
    hit_d = hit_q;
    if (ctl_i.cmp) begin
      unique case (ctl_i.op)
        mmq_pkg::OP_TAKE: hit_d = valid && eq;
        mmq_pkg::OP_POP:  hit_d = last;
        default:          hit_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // first hit from the oldest end claims the transfer
  always_comb begin
    chain_o.found = chain_i.found | hit_q;
    chain_o.entry = (!chain_i.found && hit_q) ? entry_q : chain_i.entry;
  end

  assign remove = (ctl_i.op == mmq_pkg::OP_TAKE || ctl_i.op == mmq_pkg::OP_POP)
               && (chain_i.found || hit_q);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.exe) begin
      if (ctl_i.op == mmq_pkg::OP_INSERT && count_i == CW'(IDX)) begin
        entry_d = req_i;
      end else if (remove) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ hw/rtl/message_match_queue_top.sv @@
// message match queue: insert, pop newest, take oldest match over a row of slots
// result strobe: registered after the compare step and then the shift step that follow acceptance
// a new operation is accepted only while busy is low; busy is high for the compare cycle
// the take path ripples the first-hit flag combinationally through the slot row
// reset: occupancy clears to zero, slot contents stay undefined until written
// results cannot be stalled: done_o marks each transfer for exactly one cycle
`default_nettype none
module message_match_queue_top #(
  parameter int unsigned DEPTH = mmq_pkg::DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               opcode_i,
  input  wire logic signed [31:0]       msg_tag_i,
  input  wire logic [3:0]               msg_source_i,
  input  wire logic [30:0]              msg_length_i,
  input  wire logic [15:0]              packet_ref_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [15:0]                   out_ref_o,
  output logic signed [31:0]            out_tag_o,
  output logic [3:0]                    out_source_o,
  output logic [30:0]                   out_length_o,
  output logic [4:0]                    occupancy_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  mmq_pkg::entry_t req_q, req_d;
  mmq_pkg::op_e    op_q, op_d;
  logic            busy_q, exe_q, done_q;
  logic [CW-1:0]   count_q, count_d;
  logic [1:0]      status_q, status_d;
  mmq_pkg::entry_t res_q;
  logic [31:0]     count_ext;
  logic            accept;
  mmq_pkg::ctl_t   ctl;

  mmq_pkg::chain_t chain [DEPTH+1];
  mmq_pkg::entry_t ent   [DEPTH+1];

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_comb begin
    req_d = req_q;
    op_d  = op_q;
    if (accept) begin
      req_d.tag    = msg_tag_i;
      req_d.source = msg_source_i;
      req_d.length = msg_length_i;
      req_d.pref   = packet_ref_i;
      op_d         = mmq_pkg::op_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= mmq_pkg::OP_INSERT;
      busy_q <= 1'b0;
      exe_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      op_q   <= op_d;
      busy_q <= accept;
      exe_q  <= busy_q;
      done_q <= exe_q;
    end
  end

  assign ctl.cmp = busy_q;
  assign ctl.exe = exe_q;
  assign ctl.op  = op_q;

  assign chain[0] = '0;
  assign ent[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mmq_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .req_i  (req_q),
      .count_i(count_q),
      .next_i (ent[i+1]),
      .chain_i(chain[i]),
      .chain_o(chain[i+1]),
      .entry_o(ent[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (exe_q) begin
      status_d = mmq_pkg::ST_EMPTY;
      unique case (op_q) inside
        mmq_pkg::OP_INSERT: begin
          if (count_q == CW'(DEPTH)) begin
            status_d = mmq_pkg::ST_FULL;
          end else begin
            status_d = mmq_pkg::ST_OK;
            count_d  = count_q + CW'(1);
          end
        end
        mmq_pkg::OP_POP, mmq_pkg::OP_TAKE: begin
          if (chain[DEPTH].found) begin
            status_d = mmq_pkg::ST_OK;
            count_d  = count_q - CW'(1);
          end
        end
        default: status_d = mmq_pkg::ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (exe_q) begin
      res_q <= chain[DEPTH].entry;
    end
  end

  assign count_ext    = 32'(count_q);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_ref_o    = res_q.pref;
  assign out_tag_o    = res_q.tag;
  assign out_source_o = res_q.source;
  assign out_length_o = res_q.length;
  assign occupancy_o  = count_ext[4:0];

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_one_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && exe_q)
    else $error("compare phase not followed by execute");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(exe_q) && $past(busy_q, 2))
    else $error("result strobe without a transfer");

  a_full_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != mmq_pkg::ST_OK |-> res_q == '0)
    else $error("failed operation returned entry data");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exe_q |=> $stable(count_q))
    else $error("occupancy changed outside execute");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// testbench for the message match queue: random and directed operations checked against a model
`timescale 1ns / 1ps

localparam int unsigned QDEPTH = mmq_pkg::DepthDefault;

typedef struct {
  mmq_pkg::status_e status;
  logic [15:0]      pref;
  logic [31:0]      tag;
  logic [3:0]       source;
  logic [30:0]      length;
  logic [4:0]       occ;
} reply_t;

class mmq_scoreboard;
  mmq_pkg::entry_t slots [QDEPTH];
  int unsigned     held;
  reply_t          awaited [$];
  int unsigned     mismatches, replies_seen;
  int unsigned     n_insert, n_pop, n_take, n_unused, n_removed, n_full, n_empty;

  function int unsigned pending();
    return awaited.size();
  endfunction

  // predict the reply of one accepted operation and update the modeled store
  function void note(logic [1:0] op, logic [31:0] tag, logic [3:0] source,
                     logic [30:0] length, logic [15:0] pref);
    reply_t r;
    int     hit;
    r.status = mmq_pkg::ST_EMPTY;
    r.pref   = '0;
    r.tag    = '0;
    r.source = '0;
    r.length = '0;
    hit      = -1;
    case (op)
      mmq_pkg::OP_INSERT: begin
        n_insert++;
        if (held >= QDEPTH) begin
          r.status = mmq_pkg::ST_FULL;
        end else begin
          slots[held].tag    = tag;
          slots[held].source = source;
          slots[held].length = length;
          slots[held].pref   = pref;
          held++;
          r.status = mmq_pkg::ST_OK;
        end
      end
      mmq_pkg::OP_POP: begin
        n_pop++;
        if (held != 0) begin
          held--;
          hit = held;
        end
      end
      mmq_pkg::OP_TAKE: begin
        n_take++;
        for (int i = 0; i < held; i++) begin
          if (slots[i].tag == tag && slots[i].source == source &&
              slots[i].length == length) begin
            hit = i;
            break;
          end
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (hit >= 0) begin
      r.status = mmq_pkg::ST_OK;
      r.pref   = slots[hit].pref;
      r.tag    = slots[hit].tag;
      r.source = slots[hit].source;
      r.length = slots[hit].length;
      n_removed++;
      if (op == mmq_pkg::OP_TAKE) begin
        for (int j = hit; j + 1 < held; j++) begin
          slots[j] = slots[j + 1];
        end
        held--;
      end
    end
    if (r.status == mmq_pkg::ST_FULL) n_full++;
    if (r.status == mmq_pkg::ST_EMPTY) n_empty++;
    r.occ = held[4:0];
    awaited.push_back(r);
  endfunction

  task report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("mismatch on %s at result %0d: expected %h, got %h",
             what, replies_seen, want, got);
  endtask

  task check(logic [1:0] status, logic [15:0] pref, logic [31:0] tag,
             logic [3:0] source, logic [30:0] length, logic [4:0] occ);
    reply_t want;
    replies_seen++;
    if (awaited.size() == 0) begin
      report("unexpected result", '0, {30'd0, status});
    end else begin
      want = awaited.pop_front();
      if (status !== want.status) report("status", 32'(want.status), 32'(status));
      if (pref !== want.pref) report("out_ref", 32'(want.pref), 32'(pref));
      if (tag !== want.tag) report("out_tag", want.tag, tag);
      if (source !== want.source) report("out_source", 32'(want.source), 32'(source));
      if (length !== want.length) report("out_length", 32'(want.length), 32'(length));
      if (occ !== want.occ) report("occupancy", 32'(want.occ), 32'(occ));
    end
  endtask
endclass

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic signed [31:0] msg_tag;
  logic [3:0]         msg_source;
  logic [30:0]        msg_length;
  logic [15:0]        packet_ref;
  logic               done;
  logic [1:0]         status;
  logic [15:0]        out_ref;
  logic signed [31:0] out_tag;
  logic [3:0]         out_source;
  logic [30:0]        out_length;
  logic [4:0]         occupancy;

  mmq_scoreboard book;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  message_match_queue_top #(.DEPTH(QDEPTH)) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode),
    .msg_tag_i    (msg_tag),
    .msg_source_i (msg_source),
    .msg_length_i (msg_length),
    .packet_ref_i (packet_ref),
    .done_o       (done),
    .status_o     (status),
    .out_ref_o    (out_ref),
    .out_tag_o    (out_tag),
    .out_source_o (out_source),
    .out_length_o (out_length),
    .occupancy_o  (occupancy)
  );

  always @(posedge clk) begin
    if (rst_n && done) begin
      book.check(status, out_ref, out_tag, out_source, out_length, occupancy);
    end
  end

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [3:0] pick_source();
    return 4'($urandom_range(0, $urandom_range(0, 1) ? 15 : 1));
  endfunction

  function automatic logic [30:0] pick_length();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(0, 3));
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepts the transfer
  task automatic issue(logic [1:0] op, logic [31:0] tag, logic [3:0] source,
                       logic [30:0] length, logic [15:0] pref);
    start      <= 1'b1;
    opcode     <= op;
    msg_tag    <= tag;
    msg_source <= source;
    msg_length <= length;
    packet_ref <= pref;
    do @(posedge clk); while (busy !== 1'b0);
    book.note(op, tag, source, length, pref);
  endtask

  // idle with junk on the fields
  task automatic pause(int unsigned cycles);
    start      <= 1'b0;
    opcode     <= 2'($urandom());
    msg_tag    <= $urandom();
    msg_source <= 4'($urandom());
    msg_length <= 31'($urandom());
    packet_ref <= 16'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  initial begin
    logic [31:0] tag;
    logic [3:0]  src;
    logic [30:0] len;
    logic [15:0] pref;
    int unsigned roll, k, item, next_hold;
    bit          filling, quiet;
    book       = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    opcode     = mmq_pkg::OP_INSERT;
    msg_tag    = '0;
    msg_source = '0;
    msg_length = '0;
    packet_ref = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store
    issue(mmq_pkg::OP_POP, 32'h0, 4'h0, 31'h0, 16'h0);
    issue(mmq_pkg::OP_TAKE, 32'h0, 4'h0, 31'h0, 16'h0);
    // extremes and a duplicate key
    issue(mmq_pkg::OP_INSERT, 32'h8000_0000, 4'hF, 31'h7FFF_FFFF, 16'hFFFF);
    issue(mmq_pkg::OP_INSERT, 32'h7FFF_FFFF, 4'h0, 31'h0, 16'h0);
    pause(3);
    issue(mmq_pkg::OP_INSERT, 32'h8000_0000, 4'hF, 31'h7FFF_FFFF, 16'h1234);
    issue(mmq_pkg::OP_INSERT, 32'hFFFF_FFFF, 4'h5, 31'd12345, 16'h00A5);
    // near misses on each key field
    issue(mmq_pkg::OP_TAKE, 32'h8000_0001, 4'hF, 31'h7FFF_FFFF, 16'h0);
    issue(mmq_pkg::OP_TAKE, 32'h8000_0000, 4'hE, 31'h7FFF_FFFF, 16'h0);
    pause(1);
    issue(mmq_pkg::OP_TAKE, 32'h8000_0000, 4'hF, 31'h7FFF_FFFE, 16'h0);
    // oldest duplicate first, with shift
    issue(mmq_pkg::OP_TAKE, 32'h8000_0000, 4'hF, 31'h7FFF_FFFF, 16'h5555);
    issue(OP_UNUSED, 32'h8000_0000, 4'hF, 31'h7FFF_FFFF, 16'h0);
    issue(mmq_pkg::OP_POP, 32'h0, 4'h0, 31'h0, 16'h0);
    // fill up, refuse, then take first and last slots
    repeat (QDEPTH - book.held) begin
      issue(mmq_pkg::OP_INSERT, $urandom(), 4'($urandom()), 31'($urandom()),
            16'($urandom()));
    end
    issue(mmq_pkg::OP_INSERT, 32'h1, 4'h1, 31'h1, 16'h1);
    issue(mmq_pkg::OP_TAKE, book.slots[0].tag, book.slots[0].source,
          book.slots[0].length, 16'h0);
    k = book.held - 1;
    issue(mmq_pkg::OP_TAKE, book.slots[k].tag, book.slots[k].source,
          book.slots[k].length, 16'h0);
    settle();

    item      = 0;
    next_hold = 400;
    while (item < 1900) begin
      filling = ((item / 60) % 2) == 0;
      quiet   = (item >= 700 && item < 1000);
      roll    = $urandom_range(0, 99);
      pref    = 16'($urandom());
      tag     = pick_tag();
      src     = pick_source();
      len     = pick_length();
      if (roll < (filling ? 65 : 22)) begin
        issue(mmq_pkg::OP_INSERT, tag, src, len, pref);
        item++;
      end else if (roll < (filling ? 78 : 50)) begin
        issue(mmq_pkg::OP_POP, tag, src, len, pref);
        item++;
      end else if (roll < 97) begin
        if (book.held != 0 && $urandom_range(0, 99) < 70) begin
          k   = $urandom_range(0, book.held - 1);
          tag = book.slots[k].tag;
          src = book.slots[k].source;
          len = book.slots[k].length;
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
              0: tag ^= 32'd1 << $urandom_range(0, 31);
              1: src ^= 4'd1 << $urandom_range(0, 3);
              default: len ^= 31'd1 << $urandom_range(0, 30);
            endcase
          end
        end
        issue(mmq_pkg::OP_TAKE, tag, src, len, pref);
        item++;
      end else begin
        issue(OP_UNUSED, tag, src, len, pref);
      end
      if (item >= next_hold) begin
        settle();
        next_hold += 400;
      end else if (!quiet && $urandom_range(0, 99) < 23) begin
        pause($urandom_range(1, 4));
      end
    end

    settle();
    pause(8);
    $display("ran %0d inserts, %0d pops, %0d takes, %0d unused opcodes; %0d results checked",
             book.n_insert, book.n_pop, book.n_take, book.n_unused, book.replies_seen);
    $display("%0d entries removed, %0d inserts refused as full, %0d empty or unmatched",
             book.n_removed, book.n_full, book.n_empty);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
